// ===== rtl/string_set_union_dedup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the string set union block
// Clocked, reset-gated implication checks in same-cycle and next-cycle form.
// ----------------------------------------------------------------------------
`ifndef STRING_SET_UNION_DEDUP_ASSERT_SVH
`define STRING_SET_UNION_DEDUP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSUD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SSUD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ssud_pkg.sv =====
// ----------------------------------------------------------------------------
// ssud_pkg
// Shared widths and parameter defaults for the string set union block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssud_pkg;

    // character and union position widths on the result channel
    localparam int CHAR_W      = 8;
    localparam int OUT_INDEX_W = 7;

    // default table geometry
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_CHARS_DEF   = 19;

endpackage

`default_nettype wire

// ===== rtl/ssud_key_store.sv =====
// ----------------------------------------------------------------------------
// ssud_key_store
// Key table storage: character memory and length memory, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssud_key_store #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_CHARS   = 19
) (
    input  wire logic                                    aclk,
    // character memory
    input  wire logic                                    ch_we,
    input  wire logic [$clog2(TABLE_DEPTH*KEY_CHARS)-1:0] ch_waddr,
    input  wire logic [ssud_pkg::CHAR_W-1:0]             ch_wdata,
    input  wire logic [$clog2(TABLE_DEPTH*KEY_CHARS)-1:0] ch_raddr,
    output logic      [ssud_pkg::CHAR_W-1:0]             ch_rdata,
    // length memory
    input  wire logic                                    len_we,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]          len_waddr,
    input  wire logic [$clog2(KEY_CHARS+1)-1:0]          len_wdata,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]          len_raddr,
    output logic      [$clog2(KEY_CHARS+1)-1:0]          len_rdata
);

    import ssud_pkg::*;

    localparam int CH_DEPTH = TABLE_DEPTH * KEY_CHARS;
    localparam int LW       = $clog2(KEY_CHARS + 1);

    logic [CHAR_W-1:0] char_mem [CH_DEPTH];
    logic [LW-1:0]     len_mem  [TABLE_DEPTH];

    // character memory
    always_ff @(posedge aclk) begin
        if (ch_we) begin
            char_mem[ch_waddr] <= ch_wdata;
        end
        ch_rdata <= char_mem[ch_raddr];
    end

    // length memory
    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/string_set_union_dedup.sv =====
// ----------------------------------------------------------------------------
// string_set_union_dedup
// Union of two key lists with duplicate removal, one character per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one key character (s_tdata), the key end (s_tlast)
//   and two flags in s_tuser: bit 0 starts a new job (table cleared), bit 1
//   tags the key as second list. A first-list key is stored and echoed
//   without a search; a second-list key is echoed and stored only if no stored key
//   equals it. Echoed characters leave on the m_ channel with their union
//   position; a key that finds the table full gives one overflow result.
// Sequence:
//   A character that does not end a key is taken without a stall. At key
//   end, a second-list key walks the table one entry at a time through the
//   shared compare unit: it fetches an entry's length and first character,
//   then compares one character at a time until a mismatch or a full match.
//   Storing and echoing then go one character at a time, waiting on a
//   stalled m_ side; an overflow gives one result. s_tready is low meanwhile.
// Reset and stall:
//   aresetn clears the table count and partial key. A stalled m_ side holds
//   the result register and the sequencer waits on it; no result is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module string_set_union_dedup #(
    parameter int TABLE_DEPTH = ssud_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_CHARS   = ssud_pkg::KEY_CHARS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input requests
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ssud_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] char_code
    input  wire logic [1:0]                    s_tuser,   // [0] new_job, [1] list_b
    input  wire logic                          s_tlast,   // key_end
    // result requests
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,   // [7:0] out_char, [14:8] out_index
    output logic                               m_tuser,   // overflow
    output logic                               m_tlast    // out_last
);

    import ssud_pkg::*;

    localparam int CNTW = $clog2(TABLE_DEPTH + 1);
    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int LW   = $clog2(KEY_CHARS + 1);
    localparam int BW   = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int AW   = $clog2(TABLE_DEPTH * KEY_CHARS + 1);
    localparam int MAW  = $clog2(TABLE_DEPTH * KEY_CHARS);

    localparam logic [CNTW-1:0] DEPTH_C  = CNTW'(TABLE_DEPTH);
    localparam logic [LW-1:0]   KC_LEN   = LW'(KEY_CHARS);
    localparam logic [AW-1:0]   KC_ADDR  = AW'(KEY_CHARS);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LEN  = 5'b00010,
        ST_CHR  = 5'b00100,
        ST_EMIT = 5'b01000,
        ST_OVF  = 5'b10000
    } state_t;

    state_t            state_reg,  state_next;
    logic [CNTW-1:0]   count_reg,  count_next;
    logic [LW-1:0]     blen_reg,   blen_next;
    logic [LW-1:0]     klen_reg,   klen_next;
    logic [CNTW-1:0]   ent_reg,    ent_next;
    logic [AW-1:0]     sbase_reg,  sbase_next;
    logic [AW-1:0]     nbase_reg,  nbase_next;
    logic [LW-1:0]     ci_reg,     ci_next;
    logic [CHAR_W-1:0] buf_reg [KEY_CHARS];

    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_char_reg;
    logic [OUT_INDEX_W-1:0] m_idx_reg;
    logic                   m_last_reg;
    logic                   m_ovf_reg;
    logic                   m_load;
    logic                   m_load_ovf;

    // memory ports
    logic              ch_we;
    logic [AW-1:0]     ch_waddr;
    logic [AW-1:0]     ch_raddr;
    logic [CHAR_W-1:0] ch_rdata;
    logic              len_we;
    logic [LW-1:0]     len_rdata;

    // accept-side helpers
    logic              s_acc;
    logic [CNTW-1:0]   eff_count;
    logic [LW-1:0]     eff_blen;
    logic [AW-1:0]     eff_nbase;
    logic              buf_we;
    logic [LW-1:0]     blen_added;

    // compare unit
    logic [CHAR_W-1:0] buf_rd;
    logic              match_now;
    logic              last_char;
    logic              out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign eff_count = s_tuser[0] ? '0 : count_reg;
    assign eff_blen  = s_tuser[0] ? '0 : blen_reg;
    assign eff_nbase = s_tuser[0] ? '0 : nbase_reg;
    assign buf_we    = s_acc && (eff_blen < KC_LEN);
    assign blen_added = buf_we ? (eff_blen + LW'(1)) : eff_blen;

    assign buf_rd    = buf_reg[ci_reg[BW-1:0]];
    assign match_now = (len_rdata == klen_reg) && (ch_rdata == buf_rd);
    assign last_char = (ci_reg == (klen_reg - LW'(1)));
    assign out_free  = !m_valid_reg || m_tready;

    // read address: first character on entry fetch, next character while matching
    assign ch_raddr = sbase_reg + AW'(ci_reg) + ((state_reg == ST_CHR) ? AW'(1) : '0);
    assign ch_waddr = nbase_reg + AW'(ci_reg);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        blen_next    = blen_reg;
        klen_next    = klen_reg;
        ent_next     = ent_reg;
        sbase_next   = sbase_reg;
        nbase_next   = nbase_reg;
        ci_next      = ci_reg;
        m_load       = 1'b0;
        m_load_ovf   = 1'b0;
        ch_we        = 1'b0;
        len_we       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    count_next = eff_count;
                    nbase_next = eff_nbase;
                    blen_next  = blen_added;
                    if (s_tlast) begin
                        klen_next = blen_added;
                        blen_next = '0;
                        ci_next   = '0;
                        ent_next  = '0;
                        sbase_next = '0;
                        if (s_tuser[1] && (eff_count != '0)) begin
                            state_next = ST_LEN;
                        end else if (eff_count == DEPTH_C) begin
                            state_next = ST_OVF;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_LEN: begin
                // length and first character of this entry are being read
                state_next = ST_CHR;
            end
            ST_CHR: begin
                if (!match_now) begin
                    ci_next    = '0;
                    ent_next   = ent_reg + CNTW'(1);
                    sbase_next = sbase_reg + KC_ADDR;
                    if ((ent_reg + CNTW'(1)) == count_reg) begin
                        state_next = (count_reg == DEPTH_C) ? ST_OVF : ST_EMIT;
                    end else begin
                        state_next = ST_LEN;
                    end
                end else if (last_char) begin
                    // duplicate: drop the key
                    state_next = ST_IDLE;
                end else begin
                    ci_next = ci_reg + LW'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_load = 1'b1;
                    ch_we  = 1'b1;
                    if (last_char) begin
                        len_we     = 1'b1;
                        count_next = count_reg + CNTW'(1);
                        nbase_next = nbase_reg + KC_ADDR;
                        state_next = ST_IDLE;
                    end else begin
                        ci_next = ci_reg + LW'(1);
                    end
                end
            end
            ST_OVF: begin
                if (out_free) begin
                    m_load_ovf = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_load || m_load_ovf) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            blen_reg    <= '0;
            klen_reg    <= '0;
            ent_reg     <= '0;
            sbase_reg   <= '0;
            nbase_reg   <= '0;
            ci_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            blen_reg    <= blen_next;
            klen_reg    <= klen_next;
            ent_reg     <= ent_next;
            sbase_reg   <= sbase_next;
            nbase_reg   <= nbase_next;
            ci_reg      <= ci_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // key build buffer
    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_reg[eff_blen[BW-1:0]] <= s_tdata;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_char_reg <= buf_rd;
            m_idx_reg  <= OUT_INDEX_W'(count_reg);
            m_last_reg <= last_char;
            m_ovf_reg  <= 1'b0;
        end else if (m_load_ovf) begin
            m_char_reg <= '0;
            m_idx_reg  <= OUT_INDEX_W'(count_reg);
            m_last_reg <= 1'b1;
            m_ovf_reg  <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_idx_reg, m_char_reg};
    assign m_tuser  = m_ovf_reg;
    assign m_tlast  = m_last_reg;

    ssud_key_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS)
    ) u_store (
        .aclk      (aclk),
        .ch_we     (ch_we),
        .ch_waddr  (ch_waddr[MAW-1:0]),
        .ch_wdata  (buf_rd),
        .ch_raddr  (ch_raddr[MAW-1:0]),
        .ch_rdata  (ch_rdata),
        .len_we    (len_we),
        .len_waddr (count_reg[IW-1:0]),
        .len_wdata (klen_reg),
        .len_raddr (ent_reg[IW-1:0]),
        .len_rdata (len_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/ssud_checker.sv =====
// ----------------------------------------------------------------------------
// ssud_checker
// Port-level checks for the string set union block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "string_set_union_dedup_assert.svh"

module ssud_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        s_tlast,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [15:0]                 m_tdata,
    input wire logic                        m_tuser,
    input wire logic                        m_tlast
);

    // stalled result holds
    `SSUD_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "result changed under stall")

    // overflow result is a single empty character ending the request's results
    `SSUD_ASSERT_IMP(a_ovf_form, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata[7:0] == 8'd0), "malformed overflow result")

    // a key end leaves idle for the table walk, echo or overflow, so input is held off next cycle
    `SSUD_ASSERT_NXT(a_key_end_busy, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready, "ready after key end")

    // after a mid-key character the input side stays ready
    `SSUD_ASSERT_NXT(a_mid_key_ready, aclk, aresetn, s_tvalid && s_tready && !s_tlast, s_tready, "stall on mid-key character")

endmodule

bind string_set_union_dedup ssud_checker u_ssud_checker (.*);

`default_nettype wire

// ===== tb/string_set_union_dedup_checker.sv =====
// ----------------------------------------------------------------------------
// string_set_union_dedup_checker
// Watches both request channels of the union block, keeps its own copy of the
// key table, predicts every echoed character and compares it on arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_set_union_dedup_checker #(
    parameter int TABLE_DEPTH = ssud_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_CHARS   = ssud_pkg::KEY_CHARS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [ssud_pkg::CHAR_W-1:0] s_tdata,    // [7:0] char_code
    input  logic [1:0]                  s_tuser,    // [0] new_job, [1] list_b
    input  logic                        s_tlast,    // key_end
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [15:0]                 m_tdata,    // [7:0] out_char, [14:8] out_index
    input  logic                        m_tuser,    // overflow
    input  logic                        m_tlast,    // out_last
    output int                          fail_count,
    output int                          pending,
    output int                          results_seen,
    output int                          overflows_seen
);

    // one echoed character as it should leave the block
    typedef struct packed {
        logic [ssud_pkg::CHAR_W-1:0]      ch;
        logic [ssud_pkg::OUT_INDEX_W-1:0] idx;
        logic                             last;
        logic                             ovf;
    } echo_t;

    // shadow of the key table and the key under construction
    logic [7:0] key_mem [0:TABLE_DEPTH-1][0:KEY_CHARS-1];
    int         key_len [0:TABLE_DEPTH-1];
    int         entry_count;
    logic [7:0] build_buf [0:KEY_CHARS-1];
    int         build_len;

    echo_t echo_q[$];
    int    mismatches = 0;
    int    n_results = 0;
    int    n_ovf = 0;

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // absorb one input character; at key end decide store / drop / overflow
    task automatic take_char(input logic nj, input logic lb, input logic [7:0] ch,
                             input logic ke);
        int    len;
        int    e;
        int    i;
        logic  dup;
        logic  same;
        echo_t r;
        if (nj) begin
            entry_count = 0;
            build_len   = 0;
        end
        // characters past the key limit are dropped
        if (build_len < KEY_CHARS) begin
            build_buf[build_len] = ch;
            build_len++;
        end
        if (ke) begin
            len       = build_len;
            build_len = 0;
            dup       = 1'b0;
            // second-list key: search every stored key
            if (lb) begin
                for (e = 0; e < entry_count && e < TABLE_DEPTH; e++) begin
                    if (key_len[e] == len) begin
                        same = 1'b1;
                        for (i = 0; i < len; i++)
                            if (key_mem[e][i] != build_buf[i])
                                same = 1'b0;
                        if (same)
                            dup = 1'b1;
                    end
                end
            end
            if (!dup) begin
                if (entry_count >= TABLE_DEPTH) begin
                    r.ch   = '0;
                    r.idx  = entry_count[ssud_pkg::OUT_INDEX_W-1:0];
                    r.last = 1'b1;
                    r.ovf  = 1'b1;
                    echo_q.push_back(r);
                end else begin
                    for (i = 0; i < len; i++) begin
                        key_mem[entry_count][i] = build_buf[i];
                        r.ch   = build_buf[i];
                        r.idx  = entry_count[ssud_pkg::OUT_INDEX_W-1:0];
                        r.last = (i == len - 1);
                        r.ovf  = 1'b0;
                        echo_q.push_back(r);
                    end
                    key_len[entry_count] = len;
                    entry_count++;
                end
            end
        end
    endtask

    // compare one accepted result against the oldest expectation
    task automatic check_result();
        echo_t want;
        n_results++;
        if (m_tuser)
            n_ovf++;
        if (echo_q.size() == 0) begin
            report($sformatf("unexpected result char=%02h idx=%0d last=%b ovf=%b",
                             m_tdata[7:0], m_tdata[14:8], m_tlast, m_tuser));
        end else begin
            want = echo_q.pop_front();
            if (m_tdata[7:0] !== want.ch || m_tdata[14:8] !== want.idx ||
                m_tlast !== want.last || m_tuser !== want.ovf || m_tdata[15] !== 1'b0)
                report($sformatf(
                    "result %0d: got char=%02h idx=%0d last=%b ovf=%b pad=%b, want char=%02h idx=%0d last=%b ovf=%b",
                    n_results, m_tdata[7:0], m_tdata[14:8], m_tlast, m_tuser, m_tdata[15],
                    want.ch, want.idx, want.last, want.ovf));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            entry_count = 0;
            build_len   = 0;
            echo_q.delete();
        end else begin
            if (s_tvalid && s_tready)
                take_char(s_tuser[0], s_tuser[1], s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        fail_count     <= mismatches;
        pending        <= echo_q.size();
        results_seen   <= n_results;
        overflows_seen <= n_ovf;
    end

endmodule

// ===== tb/string_set_union_dedup_tb.sv =====
// ----------------------------------------------------------------------------
// string_set_union_dedup_tb
// Drives key characters into the union block: a directed opening, random jobs
// of first-list and second-list keys with many duplicates, and a job that
// fills the table to overflow. The checker beside the block judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module string_set_union_dedup_tb;

    // generous bound: several times a slow run with long stalls and full scans
    localparam longint LIMIT_NS    = 64'd8_000_000;
    // a full second-list scan of 64 long keys plus margin
    localparam int     TAIL_CYCLES = 64 * 20 + 64;
    localparam int     BUF_CHARS   = 24;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int fail_count;
    int pending;
    int results_seen;
    int overflows_seen;

    // no-idle stretches for both sides
    logic calm = 1'b0;
    int   items_sent = 0;
    int   jobs_run = 0;

    // key being sent and the keys sent in the current job
    logic [7:0] key_buf [0:BUF_CHARS-1];
    logic [7:0] hist [0:63][0:BUF_CHARS-1];
    int         hist_len [0:63];
    int         hist_n;

    string_set_union_dedup dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    string_set_union_dedup_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_seen   (results_seen),
        .overflows_seen (overflows_seen)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout: %0d results still expected", pending);
        $display("FAIL string_set_union_dedup");
        $finish;
    end

    // result side: random stall before each result request
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one character request, after a random gap
    task automatic push_char(input logic nj, input logic lb, input logic [7:0] ch,
                             input logic ke);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {lb, nj};
        s_tlast  <= ke;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // send key_buf[0..len-1]; list tag on inner characters is noise
    task automatic send_key(input logic nj, input logic lb, input int len);
        int i;
        for (i = 0; i < len; i++)
            push_char((i == 0) ? nj : 1'b0,
                      (i == len - 1) ? lb : 1'($urandom_range(0, 1)),
                      key_buf[i], i == len - 1);
    endtask

    function automatic logic [7:0] rand_char(input logic narrow);
        return narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(1, 255));
    endfunction

    // mostly short keys, some near the limit, a few past it
    function automatic int rand_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 4);
        else if (r < 9)
            return $urandom_range(5, 19);
        else
            return $urandom_range(20, BUF_CHARS - 1);
    endfunction

    task automatic fresh_key(input int len, input logic narrow);
        int i;
        for (i = 0; i < len; i++)
            key_buf[i] = rand_char(narrow);
    endtask

    task automatic recall_key(input int k, output int len);
        int i;
        len = hist_len[k];
        for (i = 0; i < len; i++)
            key_buf[i] = hist[k][i];
    endtask

    task automatic remember_key(input int len);
        int i;
        if (hist_n < 64) begin
            for (i = 0; i < len; i++)
                hist[hist_n][i] = key_buf[i];
            hist_len[hist_n] = len;
            hist_n++;
        end
    endtask

    // one union job: first-list keys, then second-list keys heavy on repeats
    task automatic run_job();
        int   k;
        int   n_a;
        int   n_b;
        int   len;
        int   r;
        logic narrow;
        calm   = ($urandom_range(0, 3) == 0);
        narrow = 1'($urandom_range(0, 1));
        hist_n = 0;
        jobs_run++;
        // broken sequence: a partial key that the new job throws away
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(1, 3);
            fresh_key(len, narrow);
            for (k = 0; k < len; k++)
                push_char(1'b0, 1'($urandom_range(0, 1)), key_buf[k], 1'b0);
        end
        n_a = $urandom_range(1, 8);
        for (k = 0; k < n_a; k++) begin
            len = rand_len();
            fresh_key(len, narrow);
            remember_key(len);
            send_key(k == 0, 1'b0, len);
        end
        n_b = $urandom_range(1, 8);
        for (k = 0; k < n_b; k++) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                recall_key($urandom_range(0, hist_n - 1), len);
            end else if (r < 7) begin
                // near miss: one character more or less
                recall_key($urandom_range(0, hist_n - 1), len);
                if (len < BUF_CHARS && (len == 1 || $urandom_range(0, 1))) begin
                    key_buf[len] = rand_char(narrow);
                    len++;
                end else begin
                    len--;
                end
            end else begin
                len = rand_len();
                fresh_key(len, narrow);
            end
            remember_key(len);
            send_key(1'b0, 1'b1, len);
        end
        // first-list key after second-list keys, often a repeat
        if ($urandom_range(0, 2) == 0) begin
            recall_key($urandom_range(0, hist_n - 1), len);
            send_key(1'b0, 1'b0, len);
        end
    endtask

    // fill the table, then push keys that find it full
    task automatic run_full_job();
        int k;
        calm = 1'b0;
        jobs_run++;
        for (k = 0; k < 66; k++) begin
            key_buf[0] = 8'(k + 1);
            send_key(k == 0, 1'b0, 1);
        end
        // duplicate while full: silent
        key_buf[0] = 8'd5;
        send_key(1'b0, 1'b1, 1);
        // new second-list key while full
        key_buf[0] = 8'hC8;
        key_buf[1] = 8'h37;
        send_key(1'b0, 1'b1, 2);
        // multi-character first-list key while full
        key_buf[0] = 8'hAA;
        key_buf[1] = 8'h55;
        key_buf[2] = 8'h0F;
        send_key(1'b0, 1'b0, 3);
    endtask

    initial begin
        int i;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening: extremes, duplicate, near miss, overlong key
        jobs_run = 1;
        key_buf[0] = 8'hFF;
        send_key(1'b1, 1'b0, 1);
        key_buf[0] = 8'h01;
        send_key(1'b0, 1'b0, 1);
        key_buf[0] = 8'hFF;
        send_key(1'b0, 1'b1, 1);
        key_buf[0] = 8'h61;
        key_buf[1] = 8'h62;
        send_key(1'b0, 1'b1, 2);
        send_key(1'b0, 1'b1, 2);
        send_key(1'b0, 1'b1, 1);
        for (i = 0; i < 20; i++)
            key_buf[i] = 8'(8'h30 + i * 11);
        send_key(1'b0, 1'b0, 20);

        // hold the sender until every echo is back
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);

        while (items_sent < 200)
            run_job();
        run_full_job();
        while (items_sent < 400)
            run_job();

        s_tvalid <= 1'b0;
        calm = 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d character requests in %0d jobs", items_sent, jobs_run);
        $display("checked %0d results, %0d of them overflow", results_seen, overflows_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASS string_set_union_dedup");
        else
            $display("FAIL string_set_union_dedup");
        $finish;
    end

endmodule
